/* rtl/core/aw3_pkg.sv */
// Shared types and constants for the 3D aggregation walker.
package aw3_pkg;

  localparam int XW = 8;
  localparam int YW = 4;
  localparam int ZW = 8;
  localparam int DW = 3;
  localparam int SW = 2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [DW-1:0] DIR_XP = 3'd0;
  localparam logic [DW-1:0] DIR_XN = 3'd1;
  localparam logic [DW-1:0] DIR_YP = 3'd2;
  localparam logic [DW-1:0] DIR_YN = 3'd3;
  localparam logic [DW-1:0] DIR_ZP = 3'd4;
  localparam logic [DW-1:0] DIR_ZN = 3'd5;

  localparam logic [SW-1:0] ST_MOVING   = 2'd0;
  localparam logic [SW-1:0] ST_NEIGHBOR = 2'd1;
  localparam logic [SW-1:0] ST_EDGE     = 2'd2;
  localparam logic [SW-1:0] ST_NONE     = 2'd3;

  typedef struct packed {
    logic          op;
    logic [XW-1:0] start_x;
    logic [YW-1:0] start_y;
    logic [ZW-1:0] start_z;
    logic [DW-1:0] direction;
  } in_word_t;

  typedef struct packed {
    logic [SW-1:0] status;
    logic [XW-1:0] pos_x;
    logic [YW-1:0] pos_y;
    logic [ZW-1:0] pos_z;
    logic [XW-1:0] prev_x;
    logic [YW-1:0] prev_y;
    logic [ZW-1:0] prev_z;
  } out_word_t;

  typedef struct packed {
    logic clear_row;
    logic load;
    logic start_scan;
    logic rd;
    logic finish;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic no_walker;
    logic shell;
    logic rd_last;
    logic out_busy;
  } dp_stat_t;

endpackage

/* rtl/core/aw3_occ.sv */
// Occupancy bitmap: one x-row per word, row clear or single bit set, registered read.
module aw3_occ #(
  parameter int ROWS = 4096,
  parameter int COLS = 256
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic                    wr_clear,
  input  logic [$clog2(ROWS)-1:0] wr_row,
  input  logic [$clog2(COLS)-1:0] wr_col,
  input  logic                    rd_en,
  input  logic [$clog2(ROWS)-1:0] rd_row,
  output logic [COLS-1:0]         rd_data
);

  logic [COLS-1:0] mem_r [ROWS];
  logic [COLS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_clear) begin
        mem_r[wr_row] <= '0;
      end else begin
        mem_r[wr_row][wr_col] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_row];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/aw3_ctrl.sv */
// Sequencer for clearing, position update, neighbor scan and result hand-off.
module aw3_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  aw3_pkg::dp_stat_t  stat,
  output aw3_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_EVAL   = 7'b0000100,
    S_READ   = 7'b0001000,
    S_WAIT   = 7'b0010000,
    S_DECIDE = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_row = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.no_walker || stat.shell) begin
          cmd.finish = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          cmd.start_scan = 1'b1;
          state_nxt      = S_READ;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        if (stat.rd_last) state_nxt = S_WAIT;
      end
      S_WAIT: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/aw3_dp.sv */
// Walker registers, shell test, neighbor scan addressing and output register.
module aw3_dp #(
  parameter int GRID_X = 256,
  parameter int GRID_Y = 16,
  parameter int GRID_Z = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  aw3_pkg::in_word_t                    in_data,
  input  aw3_pkg::ctrl_cmd_t                   cmd,
  output aw3_pkg::dp_stat_t                    stat,
  output logic                                 mem_wr_en,
  output logic                                 mem_wr_clear,
  output logic [$clog2(GRID_Y*GRID_Z)-1:0]     mem_wr_row,
  output logic [$clog2(GRID_X)-1:0]            mem_wr_col,
  output logic                                 mem_rd_en,
  output logic [$clog2(GRID_Y*GRID_Z)-1:0]     mem_rd_row,
  input  logic [GRID_X-1:0]                    mem_rd_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output aw3_pkg::out_word_t                   out_data
);

  localparam int ROWS  = GRID_Y * GRID_Z;
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(GRID_X);
  localparam int CW    = 11;
  localparam logic [CW-1:0] GX    = CW'(GRID_X);
  localparam logic [CW-1:0] GY    = CW'(GRID_Y);
  localparam logic [CW-1:0] GZ    = CW'(GRID_Z);
  localparam logic [CW-1:0] GX_M1 = CW'(GRID_X - 1);
  localparam logic [CW-1:0] GY_M1 = CW'(GRID_Y - 1);
  localparam logic [CW-1:0] GZ_M1 = CW'(GRID_Z - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
  localparam logic [ROW_W-1:0] ROW_MUL  = ROW_W'(GRID_Y);

  logic [aw3_pkg::XW-1:0] walker_x_r, walker_x_nxt, before_x_r, before_x_nxt;
  logic [aw3_pkg::YW-1:0] walker_y_r, walker_y_nxt, before_y_r, before_y_nxt;
  logic [aw3_pkg::ZW-1:0] walker_z_r, walker_z_nxt, before_z_r, before_z_nxt;
  logic                   active_r, active_nxt;
  logic                   no_walker_r, no_walker_nxt;
  logic [ROW_W-1:0]       clr_cnt_r;
  logic [1:0]             dy_r, dz_r;
  logic                   rd_pend_r, rd_mid_r, hit_r;
  logic [aw3_pkg::SW-1:0] status_r, status_nxt;
  logic                   out_valid_r;
  aw3_pkg::out_word_t     out_data_r;

  logic [CW-1:0] xe, ye, ze;
  logic          shell, in_grid, stick;
  logic [4:0]    yy;
  logic [8:0]    zz, xm, xp;
  logic [ROW_W-1:0] cell_row;
  logic          nb_bits;

  assign xe = CW'(walker_x_r);
  assign ye = CW'(walker_y_r);
  assign ze = CW'(walker_z_r);

  assign shell = (xe == '0) || (ye == '0) || (ze == '0) ||
                 (xe >= GX_M1) || (ye >= GY_M1) || (ze >= GZ_M1);
  assign in_grid = (xe < GX) && (ye < GY) && (ze < GZ);

  // neighbor row: (z + dz - 1, y + dy - 1); only used strictly inside the shell
  assign yy = 5'(walker_y_r) + 5'(dy_r) - 5'd1;
  assign zz = 9'(walker_z_r) + 9'(dz_r) - 9'd1;
  assign xm = 9'(walker_x_r) - 9'd1;
  assign xp = 9'(walker_x_r) + 9'd1;

  assign mem_rd_row = ROW_W'(ROW_W'(zz) * ROW_MUL + ROW_W'(yy));
  assign cell_row   = ROW_W'(ROW_W'(walker_z_r) * ROW_MUL + ROW_W'(walker_y_r));
  assign mem_rd_en  = cmd.rd;

  assign nb_bits = mem_rd_data[COL_W'(xm)] | mem_rd_data[COL_W'(xp)] |
                   (!rd_mid_r & mem_rd_data[COL_W'(walker_x_r)]);

  always_comb begin
    if (no_walker_r) begin
      status_nxt = aw3_pkg::ST_NONE;
    end else if (shell) begin
      status_nxt = aw3_pkg::ST_EDGE;
    end else if (hit_r) begin
      status_nxt = aw3_pkg::ST_NEIGHBOR;
    end else begin
      status_nxt = aw3_pkg::ST_MOVING;
    end
  end

  assign stick = cmd.finish && (status_nxt == aw3_pkg::ST_EDGE ||
                                status_nxt == aw3_pkg::ST_NEIGHBOR);

  assign mem_wr_en    = cmd.clear_row || (stick && in_grid);
  assign mem_wr_clear = cmd.clear_row;
  assign mem_wr_row   = cmd.clear_row ? clr_cnt_r : cell_row;
  assign mem_wr_col   = COL_W'(walker_x_r);

  always_comb begin
    walker_x_nxt  = walker_x_r;
    walker_y_nxt  = walker_y_r;
    walker_z_nxt  = walker_z_r;
    before_x_nxt  = before_x_r;
    before_y_nxt  = before_y_r;
    before_z_nxt  = before_z_r;
    active_nxt    = active_r;
    no_walker_nxt = no_walker_r;
    if (cmd.load) begin
      no_walker_nxt = (in_data.op == aw3_pkg::OP_STEP) && !active_r;
      if (in_data.op == aw3_pkg::OP_START) begin
        walker_x_nxt = in_data.start_x;
        walker_y_nxt = in_data.start_y;
        walker_z_nxt = in_data.start_z;
        before_x_nxt = in_data.start_x;
        before_y_nxt = in_data.start_y;
        before_z_nxt = in_data.start_z;
        active_nxt   = 1'b1;
      end else if (active_r) begin
        before_x_nxt = walker_x_r;
        before_y_nxt = walker_y_r;
        before_z_nxt = walker_z_r;
        case (in_data.direction)
          aw3_pkg::DIR_XP: walker_x_nxt = walker_x_r + 1'b1;
          aw3_pkg::DIR_XN: walker_x_nxt = walker_x_r - 1'b1;
          aw3_pkg::DIR_YP: walker_y_nxt = walker_y_r + 1'b1;
          aw3_pkg::DIR_YN: walker_y_nxt = walker_y_r - 1'b1;
          aw3_pkg::DIR_ZP: walker_z_nxt = walker_z_r + 1'b1;
          aw3_pkg::DIR_ZN: walker_z_nxt = walker_z_r - 1'b1;
          default: ;
        endcase
      end
    end
    if (stick) begin
      active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walker_x_r  <= '0;
      walker_y_r  <= '0;
      walker_z_r  <= '0;
      before_x_r  <= '0;
      before_y_r  <= '0;
      before_z_r  <= '0;
      active_r    <= 1'b0;
      no_walker_r <= 1'b0;
      clr_cnt_r   <= '0;
      dy_r        <= '0;
      dz_r        <= '0;
      rd_pend_r   <= 1'b0;
      rd_mid_r    <= 1'b0;
      hit_r       <= 1'b0;
      status_r    <= aw3_pkg::ST_MOVING;
      out_valid_r <= 1'b0;
    end else begin
      walker_x_r  <= walker_x_nxt;
      walker_y_r  <= walker_y_nxt;
      walker_z_r  <= walker_z_nxt;
      before_x_r  <= before_x_nxt;
      before_y_r  <= before_y_nxt;
      before_z_r  <= before_z_nxt;
      active_r    <= active_nxt;
      no_walker_r <= no_walker_nxt;
      if (cmd.clear_row) clr_cnt_r <= clr_cnt_r + 1'b1;
      rd_pend_r <= cmd.rd;
      rd_mid_r  <= cmd.rd && (dy_r == 2'd1) && (dz_r == 2'd1);
      if (cmd.start_scan) begin
        dy_r  <= '0;
        dz_r  <= '0;
        hit_r <= 1'b0;
      end else begin
        if (cmd.rd) begin
          if (dy_r == 2'd2) begin
            dy_r <= '0;
            dz_r <= dz_r + 1'b1;
          end else begin
            dy_r <= dy_r + 1'b1;
          end
        end
        if (rd_pend_r) hit_r <= hit_r | nb_bits;
      end
      if (cmd.finish) status_r <= status_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.status <= status_r;
      if (no_walker_r) begin
        out_data_r.pos_x  <= '0;
        out_data_r.pos_y  <= '0;
        out_data_r.pos_z  <= '0;
        out_data_r.prev_x <= '0;
        out_data_r.prev_y <= '0;
        out_data_r.prev_z <= '0;
      end else begin
        out_data_r.pos_x  <= walker_x_r;
        out_data_r.pos_y  <= walker_y_r;
        out_data_r.pos_z  <= walker_z_r;
        out_data_r.prev_x <= before_x_r;
        out_data_r.prev_y <= before_y_r;
        out_data_r.prev_z <= before_z_r;
      end
    end
  end

  assign stat.clr_last  = (clr_cnt_r == ROW_LAST);
  assign stat.no_walker = no_walker_r;
  assign stat.shell     = shell;
  assign stat.rd_last   = (dy_r == 2'd2) && (dz_r == 2'd2);
  assign stat.out_busy  = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/aggregation_walker_3d_unit.sv */
// Top level of the 3D aggregation walker: sequencer, datapath and occupancy bitmap.
// A word on the shell or with no walker goes from the shell test straight to the output;
//   inside the shell it first makes nine reads of neighbor x-rows through the read port,
//   and a new word is accepted only once the last result is loaded, which waits while out_busy.
// Reset: rst_n low clears control and walker state; then a clearing pass writes
//   GRID_Y*GRID_Z rows (4096 by default) with in_ready low.
module aggregation_walker_3d_unit #(
  parameter int GRID_X = 256,
  parameter int GRID_Y = 16,
  parameter int GRID_Z = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  aw3_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output aw3_pkg::out_word_t out_data
);

  localparam int ROWS  = GRID_Y * GRID_Z;
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(GRID_X);

  aw3_pkg::ctrl_cmd_t cmd;
  aw3_pkg::dp_stat_t  stat;

  logic             mem_wr_en;
  logic             mem_wr_clear;
  logic [ROW_W-1:0] mem_wr_row;
  logic [COL_W-1:0] mem_wr_col;
  logic             mem_rd_en;
  logic [ROW_W-1:0] mem_rd_row;
  logic [GRID_X-1:0] mem_rd_data;

  aw3_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  aw3_dp #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data      (in_data),
    .cmd          (cmd),
    .stat         (stat),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_clear (mem_wr_clear),
    .mem_wr_row   (mem_wr_row),
    .mem_wr_col   (mem_wr_col),
    .mem_rd_en    (mem_rd_en),
    .mem_rd_row   (mem_rd_row),
    .mem_rd_data  (mem_rd_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

  aw3_occ #(
    .ROWS (ROWS),
    .COLS (GRID_X)
  ) u_occ (
    .clk      (clk),
    .wr_en    (mem_wr_en),
    .wr_clear (mem_wr_clear),
    .wr_row   (mem_wr_row),
    .wr_col   (mem_wr_col),
    .rd_en    (mem_rd_en),
    .rd_row   (mem_rd_row),
    .rd_data  (mem_rd_data)
  );

endmodule

/* tb/sv/tb_aggregation_walker_3d_unit.sv */
// Self-checking testbench for aggregation_walker_3d_unit: random walks scored word by word.
`timescale 1ns / 1ps

module tb_aggregation_walker_3d_unit;

  localparam int GRID_X = 256;
  localparam int GRID_Y = 16;
  localparam int GRID_Z = 256;
  localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
  localparam int PHASE_WORDS = 650;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_WALK = 60;

  // direction codes that leave the walker in place
  localparam logic [aw3_pkg::DW-1:0] DIR_STAY_A = 3'd6;
  localparam logic [aw3_pkg::DW-1:0] DIR_STAY_B = 3'd7;

  class walker_scoreboard;
    bit occupied [CELLS];
    bit [aw3_pkg::XW-1:0] wx, bx;
    bit [aw3_pkg::YW-1:0] wy, by;
    bit [aw3_pkg::ZW-1:0] wz, bz;
    bit walker_on;
    aw3_pkg::out_word_t expected_q[$];
    int mismatches;
    int checked;
    int n_moving, n_neighbor, n_edge, n_none;

    function bit in_grid(int x, int y, int z);
      return x >= 0 && y >= 0 && z >= 0 && x < GRID_X && y < GRID_Y && z < GRID_Z;
    endfunction

    function int cell_index(int x, int y, int z);
      return (z * GRID_Y + y) * GRID_X + x;
    endfunction

    function bit near_aggregate(int x, int y, int z);
      for (int dz = -1; dz <= 1; dz++)
        for (int dy = -1; dy <= 1; dy++)
          for (int dx = -1; dx <= 1; dx++) begin
            if (dx == 0 && dy == 0 && dz == 0) continue;
            if (in_grid(x + dx, y + dy, z + dz) &&
                occupied[cell_index(x + dx, y + dy, z + dz)]) return 1'b1;
          end
      return 1'b0;
    endfunction

    // advance the walker by one accepted input word and queue the expected result
    function void note_input(aw3_pkg::in_word_t w);
      aw3_pkg::out_word_t e;
      int x, y, z;
      e = '0;
      if (w.op == aw3_pkg::OP_START) begin
        wx = w.start_x;
        wy = w.start_y;
        wz = w.start_z;
        bx = wx;
        by = wy;
        bz = wz;
        walker_on = 1'b1;
      end else if (!walker_on) begin
        e.status = aw3_pkg::ST_NONE;
        n_none++;
        expected_q.push_back(e);
        return;
      end else begin
        bx = wx;
        by = wy;
        bz = wz;
        case (w.direction)
          aw3_pkg::DIR_XP: wx = wx + 1'b1;
          aw3_pkg::DIR_XN: wx = wx - 1'b1;
          aw3_pkg::DIR_YP: wy = wy + 1'b1;
          aw3_pkg::DIR_YN: wy = wy - 1'b1;
          aw3_pkg::DIR_ZP: wz = wz + 1'b1;
          aw3_pkg::DIR_ZN: wz = wz - 1'b1;
          default: ;
        endcase
      end
      x = int'(wx);
      y = int'(wy);
      z = int'(wz);
      if (x == 0 || y == 0 || z == 0 || x >= GRID_X - 1 || y >= GRID_Y - 1 ||
          z >= GRID_Z - 1) begin
        e.status = aw3_pkg::ST_EDGE;
        n_edge++;
      end else if (near_aggregate(x, y, z)) begin
        e.status = aw3_pkg::ST_NEIGHBOR;
        n_neighbor++;
      end else begin
        e.status = aw3_pkg::ST_MOVING;
        n_moving++;
      end
      if (e.status != aw3_pkg::ST_MOVING) begin
        if (in_grid(x, y, z)) occupied[cell_index(x, y, z)] = 1'b1;
        walker_on = 1'b0;
      end
      e.pos_x = wx;
      e.pos_y = wy;
      e.pos_z = wz;
      e.prev_x = bx;
      e.prev_y = by;
      e.prev_z = bz;
      expected_q.push_back(e);
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      mismatches++;
      if (mismatches <= 40)
        $display("[%0t] mismatch %0d: %s got %0d want %0d", $time, mismatches, what, got, want);
    endtask

    task check_result(aw3_pkg::out_word_t r);
      aw3_pkg::out_word_t e;
      if (expected_q.size() == 0) begin
        report_mismatch("word with none pending, status", 32'(r.status), 0);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (r.status !== e.status) report_mismatch("status", 32'(r.status), 32'(e.status));
      if (r.pos_x !== e.pos_x) report_mismatch("pos_x", 32'(r.pos_x), 32'(e.pos_x));
      if (r.pos_y !== e.pos_y) report_mismatch("pos_y", 32'(r.pos_y), 32'(e.pos_y));
      if (r.pos_z !== e.pos_z) report_mismatch("pos_z", 32'(r.pos_z), 32'(e.pos_z));
      if (r.prev_x !== e.prev_x) report_mismatch("prev_x", 32'(r.prev_x), 32'(e.prev_x));
      if (r.prev_y !== e.prev_y) report_mismatch("prev_y", 32'(r.prev_y), 32'(e.prev_y));
      if (r.prev_z !== e.prev_z) report_mismatch("prev_z", 32'(r.prev_z), 32'(e.prev_z));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  aw3_pkg::in_word_t in_data;
  logic out_valid;
  logic out_ready;
  aw3_pkg::out_word_t out_data;

  walker_scoreboard sb = new();
  int in_idle_pct;
  int out_idle_pct;
  int hold_left;
  int walk_len;
  int cycle_count = 0;

  aggregation_walker_3d_unit #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .GRID_Z(GRID_Z)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sb.expected_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: sample at the rising edge, pick ready at the falling edge
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready) sb.check_result(out_data);
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // called at a falling edge; returns at a falling edge with valid low
  task automatic send_word(aw3_pkg::in_word_t w);
    while ($urandom_range(99) < in_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    in_data = w;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_input(w);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain_results();
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  function automatic aw3_pkg::in_word_t start_word(int x, int y, int z);
    aw3_pkg::in_word_t w;
    w.op = aw3_pkg::OP_START;
    w.start_x = 8'(x);
    w.start_y = 4'(y);
    w.start_z = 8'(z);
    w.direction = 3'($urandom_range(7));
    return w;
  endfunction

  function automatic aw3_pkg::in_word_t step_word(logic [aw3_pkg::DW-1:0] dir);
    aw3_pkg::in_word_t w;
    bit [31:0] rnd;
    rnd = $urandom;
    w = rnd[$bits(aw3_pkg::in_word_t)-1:0];
    w.op = aw3_pkg::OP_STEP;
    w.direction = dir;
    return w;
  endfunction

  // most walkers start in a small patch just above the floor and drift down onto it
  function automatic aw3_pkg::in_word_t random_word();
    aw3_pkg::in_word_t w;
    bit [31:0] rnd;
    int unsigned pick;
    int unsigned dpick;
    rnd = $urandom;
    w = rnd[$bits(aw3_pkg::in_word_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 6) return w;
    if (!sb.walker_on || walk_len >= MAX_WALK || pick < 9) begin
      w.op = aw3_pkg::OP_START;
      walk_len = 0;
      if ($urandom_range(9) != 0) begin
        w.start_x = 8'(120 + $urandom_range(15));
        w.start_y = 4'(1 + $urandom_range(3));
        w.start_z = 8'(120 + $urandom_range(15));
      end
      return w;
    end
    w.op = aw3_pkg::OP_STEP;
    walk_len++;
    dpick = $urandom_range(99);
    if (dpick < 30) w.direction = aw3_pkg::DIR_YN;
    else if (dpick < 33) w.direction = $urandom_range(1) ? DIR_STAY_A : DIR_STAY_B;
    else w.direction = 3'($urandom_range(5));
    return w;
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_left = 0;
    walk_len = 0;
    in_idle_pct = 15;
    out_idle_pct = 88;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_word(step_word(aw3_pkg::DIR_XP));  // no walker yet
    send_word(start_word(0, 0, 0));
    send_word(start_word(255, 15, 255));
    send_word(start_word(128, 8, 128));
    send_word(step_word(aw3_pkg::DIR_XP));
    send_word(step_word(aw3_pkg::DIR_XN));
    send_word(step_word(aw3_pkg::DIR_YP));
    send_word(step_word(aw3_pkg::DIR_YN));
    send_word(step_word(aw3_pkg::DIR_ZP));
    send_word(step_word(aw3_pkg::DIR_ZN));
    send_word(step_word(DIR_STAY_A));
    send_word(step_word(DIR_STAY_B));
    send_word(start_word(40, 3, 40));      // replaces a live walker
    send_word(start_word(5, 0, 5));
    send_word(start_word(5, 1, 5));        // sits on the floor cell below
    send_word(start_word(5, 1, 5));        // own cell already set
    send_word(start_word(6, 2, 6));        // diagonal contact only
    send_word(start_word(1, 5, 1));
    send_word(step_word(aw3_pkg::DIR_XN));
    send_word(start_word(254, 14, 254));
    send_word(step_word(aw3_pkg::DIR_YP));
    send_word(step_word(aw3_pkg::DIR_ZN));  // walker already gone
    send_word(start_word(200, 7, 200));
    send_word(step_word(aw3_pkg::DIR_ZP));
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 88 : 0;
      out_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 15 : 0;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (phase == 0 && n == 300) drain_results();
        if (phase == 2 && (n == 150 || n == 450)) hold_left = 400;
        send_word(random_word());
      end
      drain_results();
    end

    repeat (30) @(posedge clk);
    $display("%0d words checked: %0d moving, %0d neighbor sticks, %0d edge sticks,",
             sb.checked, sb.n_moving, sb.n_neighbor, sb.n_edge);
    $display("%0d steps with no walker, %0d mismatches, %0d cycles", sb.n_none,
             sb.mismatches, cycle_count);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
